/* rtl/plr_pkg.sv */
// ----------------------------------------------------------------------------
// plr_pkg
// Opcodes and status codes shared by the positional list insert/remove unit.
// ----------------------------------------------------------------------------
package plr_pkg;

	// command opcodes
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_AT    = 3'd1;
	localparam logic [2:0] OP_INS_BACK  = 3'd2;
	localparam logic [2:0] OP_REM_FRONT = 3'd3;
	localparam logic [2:0] OP_REM_AT    = 3'd4;
	localparam logic [2:0] OP_REM_BACK  = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

endpackage

/* rtl/positional_list_insert_remove_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_remove_unit
// Ordered list in one RAM; inserts and removals shift the tail by one slot,
// one entry per cycle through a read-then-write pipeline.
// ----------------------------------------------------------------------------
// Sequence: a failed or no-op command finishes straight from idle; an insert at
//   the end goes to PUT; other inserts pass RUN, DRAIN, PUT; removals RUN, DRAIN.
// Commands: one command at a time; the tail moves through the single RAM
//   write port, one entry per cycle.
// Reset: count clears to zero; the RAM needs no clearing pass.
// The receiver cannot stall: the done strobe lasts exactly one cycle.
module positional_list_insert_remove_unit #(
	parameter int DEPTH       = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [6:0]  position,
	input  logic [31:0] entry_value,
	output logic        done,
	output logic [31:0] removed_value,
	output logic [1:0]  status,
	output logic [6:0]  entry_count
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int PCW = (CW > 7) ? CW : 7;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RUN   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;

	logic [2:0]             state_q;
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          ptr_q;
	logic [AW-1:0]          last_q;
	logic [AW-1:0]          pos_q;
	logic                   ins_q;
	logic [ENTRY_WIDTH-1:0] val_q;
	logic                   done_q;
	logic [1:0]             status_q;
	logic [ENTRY_WIDTH-1:0] removed_q;
	logic                   rvalid_s1;
	logic                   first_s1;
	logic [AW-1:0]          waddr_s1;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [ENTRY_WIDTH-1:0] mem_wdata;
	logic [ENTRY_WIDTH-1:0] mem_rdata;

	logic                   accept;
	logic [PCW-1:0]         count_ext;
	logic [PCW-1:0]         eff_pos;
	logic                   is_ins;
	logic                   is_rem;
	logic [1:0]             chk_status;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign count_ext = PCW'(count_q);

	// effective slot and checks for the incoming command
	always_comb begin
		is_ins  = 1'b0;
		is_rem  = 1'b0;
		eff_pos = '0;
		unique case (opcode)
			plr_pkg::OP_INS_FRONT: begin
				is_ins = 1'b1;
			end
			plr_pkg::OP_INS_AT: begin
				is_ins  = 1'b1;
				eff_pos = PCW'(position);
			end
			plr_pkg::OP_INS_BACK: begin
				is_ins  = 1'b1;
				eff_pos = count_ext;
			end
			plr_pkg::OP_REM_FRONT: begin
				is_rem = 1'b1;
			end
			plr_pkg::OP_REM_AT: begin
				is_rem  = 1'b1;
				eff_pos = PCW'(position);
			end
			plr_pkg::OP_REM_BACK: begin
				is_rem  = 1'b1;
				eff_pos = (count_q == '0) ? '0 : count_ext - PCW'(1);
			end
			default: begin
			end
		endcase

		chk_status = plr_pkg::ST_OK;
		if (is_ins) begin
			if (count_q == CW'(DEPTH))
				chk_status = plr_pkg::ST_FULL;
			else if (eff_pos > count_ext)
				chk_status = plr_pkg::ST_BADPOS;
		end else if (is_rem) begin
			if (count_q == '0)
				chk_status = plr_pkg::ST_EMPTY;
			else if (eff_pos >= count_ext)
				chk_status = plr_pkg::ST_BADPOS;
		end
	end

	// single write port: shifted entry from the pipeline, or the new entry
	always_comb begin
		if (state_q == S_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q;
			mem_wdata = val_q;
		end else begin
			mem_we    = rvalid_s1 && !first_s1;
			mem_waddr = waddr_s1;
			mem_wdata = mem_rdata;
		end
	end

	plr_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	// control sequencer and read pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			last_q    <= '0;
			done_q    <= 1'b0;
			rvalid_s1 <= 1'b0;
			first_s1  <= 1'b0;
			waddr_s1  <= '0;
		end else begin
			done_q    <= 1'b0;
			rvalid_s1 <= 1'b0;
			first_s1  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (chk_status != plr_pkg::ST_OK || !(is_ins || is_rem)) begin
							done_q <= 1'b1;
						end else if (is_ins && eff_pos == count_ext) begin
							state_q <= S_PUT;
						end else if (is_ins) begin
							ptr_q   <= AW'(count_q - CW'(1));
							last_q  <= AW'(eff_pos);
							state_q <= S_RUN;
						end else begin
							ptr_q   <= AW'(eff_pos);
							last_q  <= AW'(count_q - CW'(1));
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					rvalid_s1 <= 1'b1;
					first_s1  <= !ins_q && (ptr_q == pos_q);
					waddr_s1  <= ins_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
					if (ptr_q == last_q)
						state_q <= S_DRAIN;
					else
						ptr_q <= ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
				end
				S_DRAIN: begin
					if (ins_q) begin
						state_q <= S_PUT;
					end else begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q     <= is_ins;
			pos_q     <= AW'(eff_pos);
			val_q     <= ENTRY_WIDTH'(entry_value);
			status_q  <= chk_status;
			removed_q <= '0;
		end
		if (rvalid_s1 && first_s1)
			removed_q <= mem_rdata;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = 32'(removed_q);
	assign entry_count   = 7'(count_q);

	// accepted command either finishes next cycle or keeps the unit busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted command neither finished nor started");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == plr_pkg::ST_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("full status with room left");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != plr_pkg::ST_OK) |-> (removed_q == '0))
		else $error("failed command returned a value");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr < AW'(DEPTH - 1) || mem_waddr == AW'(DEPTH - 1)))
		else $error("slot write beyond depth");

endmodule

/* rtl/plr_ram.sv */
// ----------------------------------------------------------------------------
// plr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module plr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
